[hw/rtl/b64s_pkg.sv]
package b64s_pkg;

  localparam int RES_MAX = 3;
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);

  localparam logic [20:0] COUNT_MAX   = 21'h1FFFFF;
  localparam logic [20:0] MAX_BYTES_RST = 21'd262144;

  localparam logic        DIR_ENCODE = 1'b0;
  localparam logic        DIR_DECODE = 1'b1;

  localparam logic        CFG_DIRECTION = 1'b0;
  localparam logic        CFG_MAX_BYTES = 1'b1;

  localparam logic [1:0]  STATUS_OK       = 2'd0;
  localparam logic [1:0]  STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0]  STATUS_TOO_LONG = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       last;
    logic [1:0] status;
  } b64s_res_t;

  typedef struct packed {
    logic [15:0] acc;
    logic [3:0]  pend;
    logic [20:0] count;
    logic        drop;
  } b64s_state_t;

endpackage

[hw/rtl/b64s_step.sv]
module b64s_step
  import b64s_pkg::*;
(
  input  logic        dir,
  input  logic [20:0] max_bytes,
  input  logic [7:0]  data,
  input  logic        last,
  input  b64s_state_t st,
  output b64s_state_t st_nxt,
  output b64s_res_t   res [RES_MAX],
  output logic [1:0]  res_n
);

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'd45;
    end else begin
      c = 8'd95;
    end
    return c;
  endfunction

  // {ok, sextet}
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = {1'b1, 6'(c - 8'd65)};
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r = {1'b1, 6'(c - 8'd71)};
    end else if (c >= 8'd48 && c <= 8'd57) begin
      r = {1'b1, 6'(c + 8'd4)};
    end else if (c == 8'd45) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'd95) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

  logic [15:0] acc_e;
  logic [4:0]  p8, p1, p2;
  logic [15:0] sh1, sh2;
  logic        two, flush;
  logic [3:0]  pf;
  logic [2:0]  fl_amt;
  logic [5:0]  fl_ch;

  logic [6:0]  sx;
  logic [15:0] acc_d;
  logic [4:0]  p6, pd;
  logic        byte_done, too_long;
  logic [20:0] cnt_inc;
  logic [15:0] shd;

  always_comb begin
    acc_e  = {st.acc[7:0], data};
    p8     = {1'b0, st.pend} + 5'd8;
    p1     = p8 - 5'd6;
    sh1    = acc_e >> p1;
    two    = (p1 >= 5'd6);
    p2     = p1 - 5'd6;
    sh2    = acc_e >> p2;
    pf     = two ? p2[3:0] : p1[3:0];
    flush  = last && (pf != 4'd0) && (pf < 4'd6);
    fl_amt = 3'd6 - pf[2:0];
    fl_ch  = acc_e[5:0] << fl_amt;

    sx        = dec_char(data);
    acc_d     = {st.acc[9:0], sx[5:0]};
    p6        = {1'b0, st.pend} + 5'd6;
    byte_done = (p6 >= 5'd8);
    pd        = p6 - 5'd8;
    cnt_inc   = (st.count == COUNT_MAX) ? st.count : st.count + 21'd1;
    too_long  = (cnt_inc > max_bytes);
    shd       = acc_d >> pd;
  end

  always_comb begin
    st_nxt = st;
    for (int k = 0; k < RES_MAX; k++) begin
      res[k] = '0;
    end
    res_n = 2'd0;

    if (st.drop) begin
      if (last) begin
        st_nxt = '0;
      end
    end else if (dir == DIR_ENCODE) begin
      st_nxt.acc  = acc_e;
      st_nxt.pend = pf;
      res[0] = '{data: enc_char(sh1[5:0]), dvalid: 1'b1, last: 1'b0, status: STATUS_OK};
      res_n  = 2'd1;
      if (two) begin
        res[1] = '{data: enc_char(sh2[5:0]), dvalid: 1'b1, last: 1'b0, status: STATUS_OK};
        res_n  = 2'd2;
      end
      if (flush) begin
        if (two) begin
          res[2] = '{data: enc_char(fl_ch), dvalid: 1'b1, last: 1'b1, status: STATUS_OK};
          res_n  = 2'd3;
        end else begin
          res[1] = '{data: enc_char(fl_ch), dvalid: 1'b1, last: 1'b1, status: STATUS_OK};
          res_n  = 2'd2;
        end
      end else if (last) begin
        if (two) begin
          res[1].last = 1'b1;
        end else begin
          res[0].last = 1'b1;
        end
      end
      if (last) begin
        st_nxt = '0;
      end
    end else begin
      if (!sx[6]) begin
        res[0] = '{data: 8'd0, dvalid: 1'b0, last: 1'b1, status: STATUS_BAD_CHAR};
        res_n  = 2'd1;
        st_nxt = '0;
        st_nxt.drop = !last;
      end else if (byte_done && too_long) begin
        res[0] = '{data: 8'd0, dvalid: 1'b0, last: 1'b1, status: STATUS_TOO_LONG};
        res_n  = 2'd1;
        st_nxt = '0;
        st_nxt.drop = !last;
      end else begin
        st_nxt.acc  = acc_d;
        st_nxt.pend = byte_done ? pd[3:0] : p6[3:0];
        if (byte_done) begin
          st_nxt.count = cnt_inc;
          res[0] = '{data: shd[7:0], dvalid: 1'b1, last: last, status: STATUS_OK};
          res_n  = 2'd1;
        end else if (last) begin
          res[0] = '{data: 8'd0, dvalid: 1'b0, last: 1'b1, status: STATUS_OK};
          res_n  = 2'd1;
        end
        if (last) begin
          st_nxt = '0;
        end
      end
    end
  end

endmodule

[hw/rtl/b64s_rq.sv]
module b64s_rq
  import b64s_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  b64s_res_t        push_res [RES_MAX],
  input  logic             pop,
  output b64s_res_t        head,
  output logic [QCW-1:0]   cnt
);

  b64s_res_t        q_mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(push_n);
    rd_ptr_nxt = rd_ptr_r + QAW'(pop);
    cnt_nxt    = cnt_r + QCW'(push_n) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_MAX; k++) begin
      if (k < int'(push_n)) begin
        q_mem_r[wr_ptr_r + QAW'(k)] <= push_res[k];
      end
    end
  end

  assign head = q_mem_r[rd_ptr_r];
  assign cnt  = cnt_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCW'(QDEPTH))
    else $error("result queue over depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> (int'(cnt_r) - int'(pop) + int'(push_n)) <= QDEPTH)
    else $error("push without room");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("pop from empty queue");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> cnt_r == '0)
    else $error("queue not empty after reset");
`endif

endmodule

[hw/rtl/base64url_stream_codec.sv]
// Channel  Dir  Handshake                  Payload
// in_      in   in_tvalid / in_tready      in_tdata, in_tlast
// out_     out  out_tvalid / out_tready    out_tdata, out_tuser, out_tlast
// cfg_     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Each item passes an input register, then one pass of step logic pushes its
// 0..3 results into a 4-entry result queue; the item waits in the input
// register while the queue lacks room for three results. One item per cycle
// while items yield one result and out_tready is high; the queue drains one
// result per cycle while out_tready is high, so encoding throughput is one
// result per cycle. Synchronous active-low reset clears control and message state.
// out_tready low holds the queue, after which in_tready drops; cfg is always ready.
module base64url_stream_codec
  import b64s_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_in
  input  logic        in_tlast,

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] data_out
  output logic [2:0]  out_tuser,  // [0] data_valid, [2:1] status
  output logic        out_tlast,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [20:0] cfg_data
);

  logic        dir_r;
  logic [20:0] max_bytes_r;

  logic        s1_vld_r, s1_vld_nxt;
  logic [7:0]  s1_data_r;
  logic        s1_last_r;

  b64s_state_t st_r, st_nxt, st_step;
  b64s_res_t   step_res [RES_MAX];
  logic [1:0]  step_n;
  logic [1:0]  push_n;

  b64s_res_t      head;
  logic [QCW-1:0] q_cnt;
  logic           pop, fire, in_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= DIR_ENCODE;
      max_bytes_r <= MAX_BYTES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DIRECTION: dir_r       <= cfg_data[0];
        CFG_MAX_BYTES: max_bytes_r <= cfg_data;
        default:       dir_r       <= dir_r;
      endcase
    end
  end

  assign pop        = out_tvalid && out_tready;
  assign fire       = s1_vld_r &&
                      (int'(q_cnt) - int'(pop) <= QDEPTH - RES_MAX);
  assign in_tready  = !s1_vld_r || fire;
  assign in_acc     = in_tvalid && in_tready;
  assign s1_vld_nxt = in_acc || (s1_vld_r && !fire);
  assign push_n     = fire ? step_n : 2'd0;
  assign st_nxt     = fire ? st_step : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      st_r     <= '0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      st_r     <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  b64s_step u_step (
    .dir       (dir_r),
    .max_bytes (max_bytes_r),
    .data      (s1_data_r),
    .last      (s1_last_r),
    .st        (st_r),
    .st_nxt    (st_step),
    .res       (step_res),
    .res_n     (step_n)
  );

  b64s_rq u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (push_n),
    .push_res (step_res),
    .pop      (pop),
    .head     (head),
    .cnt      (q_cnt)
  );

  assign out_tvalid = (q_cnt != '0);
  assign out_tdata  = head.data;
  assign out_tuser  = {head.status, head.dvalid};
  assign out_tlast  = head.last;

`ifndef ASSERT_OFF
  a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("bare result without end mark");

  a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] != STATUS_OK |-> out_tlast && !out_tuser[0])
    else $error("error status on a data result");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !fire |=> s1_vld_r && $stable(s1_data_r) && $stable(s1_last_r))
    else $error("held item lost");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_last_r |=> st_r == '0)
    else $error("state not cleared at end of message");
`endif

endmodule
